[hw/rtl/timing_sample_statistics_macros.svh]
// ----------------------------------------------------------------------------
// Timing sample statistics: assertion macros
// Concurrent assertion wrappers, empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef TIMING_SAMPLE_STATISTICS_MACROS_SVH
`define TIMING_SAMPLE_STATISTICS_MACROS_SVH

`ifndef SYNTHESIS
`define TSS_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("assertion failed: name");
`define TSS_NEVER(name, clk, rstn, cond) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("assertion failed: name");
`else
`define TSS_ASSERT(name, clk, rstn, prop)
`define TSS_NEVER(name, clk, rstn, cond)
`endif

`endif

[hw/rtl/tss_pkg.sv]
// ----------------------------------------------------------------------------
// Timing sample statistics package
// Shared widths, constants, record types and the register clamp.
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam int DATA_W         = 64;
    localparam int CNT_W          = 13;
    localparam int CFG_IDX_W      = 2;
    localparam int NSQ_W          = 2 * CNT_W;
    localparam int MAX_ROW_LENGTH = 4096;
    localparam int MAX_ROWS       = 4096;

    localparam logic [DATA_W-1:0] VAR_SENTINEL = 64'd1111111111111111111;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 2'd1;

    // one finished row, front to back
    typedef struct packed {
        logic [DATA_W-1:0] row_min;
        logic [DATA_W-1:0] row_max;
        logic [DATA_W-1:0] row_sum;
        logic [DATA_W-1:0] row_sq_sum;
        logic              sq_ovf;
        logic              sum_ovf;
        logic              last;
        logic [CNT_W-1:0]  n;
        logic [CNT_W-1:0]  m;
    } row_rec_t;

    typedef struct packed {
        logic              status;
        logic [CNT_W-1:0]  spurious_count;
        logic [DATA_W-1:0] total_variance;
        logic [DATA_W-1:0] max_spread;
        logic [DATA_W-1:0] variance_of_variances;
        logic [DATA_W-1:0] variance_of_minimums;
        logic [DATA_W-1:0] least_minimum;
        logic [DATA_W-1:0] grand_sum;
    } result_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [2*DATA_W-1:0] prod;
    } mul_rsp_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [NSQ_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DATA_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] v,
                                                    input logic [CNT_W-1:0] hi);
        if (v == '0) begin
            return CNT_W'(1);
        end else if (v > hi) begin
            return hi;
        end else begin
            return v;
        end
    endfunction

endpackage

[hw/rtl/tss_mul.sv]
// ----------------------------------------------------------------------------
// Timing sample statistics: iterative multiplier
// 64x64 -> 128 product from four 32x32 partial products.
// ----------------------------------------------------------------------------
module tss_mul (
    input  logic              aclk,
    input  logic              aresetn,
    input  tss_pkg::mul_req_t req,
    output tss_pkg::mul_rsp_t rsp
);

    localparam int HALF_W = tss_pkg::DATA_W / 2;
    localparam int PROD_W = 2 * tss_pkg::DATA_W;

    logic [tss_pkg::DATA_W-1:0] a_reg;
    logic [tss_pkg::DATA_W-1:0] b_reg;
    logic [tss_pkg::DATA_W-1:0] pp_reg;
    logic [PROD_W-1:0]          acc_reg;
    logic [2:0]                 step_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [HALF_W-1:0]          op_a;
    logic [HALF_W-1:0]          op_b;
    logic [tss_pkg::DATA_W-1:0] pp_next;
    logic [PROD_W-1:0]          pp_shifted;

    // step 0: lo*lo, 1: lo*hi, 2: hi*lo, 3: hi*hi
    always_comb begin
        op_a = step_reg[1] ? a_reg[tss_pkg::DATA_W-1:HALF_W] : a_reg[HALF_W-1:0];
        op_b = step_reg[0] ? b_reg[tss_pkg::DATA_W-1:HALF_W] : b_reg[HALF_W-1:0];
        pp_next = tss_pkg::DATA_W'(op_a) * tss_pkg::DATA_W'(op_b);
    end

    // partial product registered last step belongs to step_reg - 1
    always_comb begin
        case (step_reg)
            3'd1:    pp_shifted = PROD_W'(pp_reg);
            3'd2,
            3'd3:    pp_shifted = PROD_W'(pp_reg) << HALF_W;
            3'd4:    pp_shifted = PROD_W'(pp_reg) << tss_pkg::DATA_W;
            default: pp_shifted = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                a_reg    <= req.a;
                b_reg    <= req.b;
                acc_reg  <= '0;
                step_reg <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                step_reg <= step_reg + 3'd1;
                if (step_reg < 3'd4) begin
                    pp_reg <= pp_next;
                end
                acc_reg <= acc_reg + pp_shifted;
                if (step_reg == 3'd4) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

[hw/rtl/tss_div.sv]
// ----------------------------------------------------------------------------
// Timing sample statistics: radix-2 divider
// 64-bit dividend by a row-size squared divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module tss_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  tss_pkg::div_req_t req,
    output tss_pkg::div_rsp_t rsp
);

    localparam int DW = tss_pkg::NSQ_W;

    logic [tss_pkg::DATA_W-1:0] q_reg;
    logic [DW-1:0]              rem_reg;
    logic [DW-1:0]              d_reg;
    logic [5:0]                 cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [DW:0]                trial;
    logic                       fits;

    always_comb begin
        trial = {rem_reg, q_reg[tss_pkg::DATA_W-1]};
        fits  = trial >= {1'b0, d_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                q_reg    <= req.dividend;
                d_reg    <= req.divisor;
                rem_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= fits ? DW'(trial - {1'b0, d_reg}) : DW'(trial);
                q_reg   <= {q_reg[tss_pkg::DATA_W-2:0], fits};
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

[hw/rtl/tss_queue.sv]
// ----------------------------------------------------------------------------
// Timing sample statistics: row queue
// Two-entry queue of finished rows between front and back.
// ----------------------------------------------------------------------------
module tss_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  tss_pkg::row_rec_t   push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output tss_pkg::row_rec_t   pop_data
);

    tss_pkg::row_rec_t mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

[hw/rtl/tss_front.sv]
// ----------------------------------------------------------------------------
// Timing sample statistics: front end
// Takes samples, keeps row min/max/sum/sum of squares, hands finished rows on.
// ----------------------------------------------------------------------------
module tss_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tss_pkg::DATA_W-1:0]    s_tdata,   // [63:0] sample
    input  logic [tss_pkg::CNT_W-1:0]     row_length,
    input  logic [tss_pkg::CNT_W-1:0]     row_count,
    output logic                          push_valid,
    input  logic                          push_ready,
    output tss_pkg::row_rec_t             push_data
);

    typedef enum logic [1:0] {F_IDLE, F_SQ, F_PUSH} fstate_t;

    fstate_t                    state_reg;
    logic [tss_pkg::DATA_W-1:0] row_min_reg;
    logic [tss_pkg::DATA_W-1:0] row_max_reg;
    logic [tss_pkg::DATA_W-1:0] row_sum_reg;
    logic [tss_pkg::DATA_W-1:0] row_sq_reg;
    logic                       sq_ovf_reg;
    logic                       sum_ovf_reg;
    logic [tss_pkg::CNT_W-1:0]  sample_index_reg;
    logic [tss_pkg::CNT_W-1:0]  row_index_reg;

    tss_pkg::mul_req_t          mul_req;
    tss_pkg::mul_rsp_t          mul_rsp;

    logic [tss_pkg::DATA_W:0]   sum_add;
    logic [tss_pkg::DATA_W:0]   sq_add;
    logic [tss_pkg::CNT_W-1:0]  n_next;
    logic [tss_pkg::CNT_W-1:0]  m_next;
    logic                       run_last;

    tss_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    assign s_tready      = state_reg == F_IDLE;
    assign mul_req.start = s_tvalid && s_tready;
    assign mul_req.a     = s_tdata;
    assign mul_req.b     = s_tdata;

    always_comb begin
        sum_add  = {1'b0, row_sum_reg} + {1'b0, s_tdata};
        sq_add   = {1'b0, row_sq_reg} + {1'b0, mul_rsp.prod[tss_pkg::DATA_W-1:0]};
        n_next   = sample_index_reg + tss_pkg::CNT_W'(1);
        m_next   = row_index_reg + tss_pkg::CNT_W'(1);
        run_last = m_next >= tss_pkg::clamp_cnt(row_count,
                                                tss_pkg::CNT_W'(tss_pkg::MAX_ROWS));
    end

    assign push_valid           = state_reg == F_PUSH;
    assign push_data.row_min    = row_min_reg;
    assign push_data.row_max    = row_max_reg;
    assign push_data.row_sum    = row_sum_reg;
    assign push_data.row_sq_sum = row_sq_reg;
    assign push_data.sq_ovf     = sq_ovf_reg;
    assign push_data.sum_ovf    = sum_ovf_reg;
    assign push_data.last       = run_last;
    assign push_data.n          = sample_index_reg;
    assign push_data.m          = m_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= F_IDLE;
            row_min_reg      <= '1;
            row_max_reg      <= '0;
            row_sum_reg      <= '0;
            row_sq_reg       <= '0;
            sq_ovf_reg       <= 1'b0;
            sum_ovf_reg      <= 1'b0;
            sample_index_reg <= '0;
            row_index_reg    <= '0;
        end else begin
            unique case (state_reg)
                F_IDLE: begin
                    if (s_tvalid) begin
                        if (s_tdata < row_min_reg) begin
                            row_min_reg <= s_tdata;
                        end
                        if (s_tdata > row_max_reg) begin
                            row_max_reg <= s_tdata;
                        end
                        row_sum_reg <= sum_add[tss_pkg::DATA_W-1:0];
                        if (sum_add[tss_pkg::DATA_W]) begin
                            sum_ovf_reg <= 1'b1;
                        end
                        state_reg <= F_SQ;
                    end
                end
                F_SQ: begin
                    if (mul_rsp.done) begin
                        row_sq_reg <= sq_add[tss_pkg::DATA_W-1:0];
                        if (sq_add[tss_pkg::DATA_W] ||
                            (|mul_rsp.prod[2*tss_pkg::DATA_W-1:tss_pkg::DATA_W])) begin
                            sq_ovf_reg <= 1'b1;
                        end
                        sample_index_reg <= n_next;
                        if (n_next >= tss_pkg::clamp_cnt(row_length,
                                tss_pkg::CNT_W'(tss_pkg::MAX_ROW_LENGTH))) begin
                            state_reg <= F_PUSH;
                        end else begin
                            state_reg <= F_IDLE;
                        end
                    end
                end
                F_PUSH: begin
                    if (push_ready) begin
                        row_min_reg      <= '1;
                        row_max_reg      <= '0;
                        row_sum_reg      <= '0;
                        row_sq_reg       <= '0;
                        sq_ovf_reg       <= 1'b0;
                        sum_ovf_reg      <= 1'b0;
                        sample_index_reg <= '0;
                        row_index_reg    <= run_last ? '0 : m_next;
                        state_reg        <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

endmodule

[hw/rtl/tss_back.sv]
// ----------------------------------------------------------------------------
// Timing sample statistics: back end
// Row variance, run accumulation and run-end statistics on a shared
// multiplier and divider; holds the result register.
// ----------------------------------------------------------------------------
`include "timing_sample_statistics_macros.svh"

module tss_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  tss_pkg::row_rec_t   pop_data,
    output logic                m_tvalid,
    input  logic                m_tready,
    output tss_pkg::result_t    m_result
);

    localparam int DW = tss_pkg::DATA_W;

    typedef enum logic [3:0] {
        B_IDLE, B_ROW, B_FV_SS, B_FV_SSW, B_FV_QN, B_FV_QNW, B_FV_CHK, B_FV_DIVW,
        B_FV_RET, B_PV_MUL, B_PV_MULW, B_PM_MUL, B_PM_MULW, B_RUN, B_EMIT
    } bstate_t;

    typedef enum logic [1:0] {PH_ROW, PH_VV, PH_VM} phase_t;

    bstate_t              state_reg;
    phase_t               phase_reg;
    tss_pkg::row_rec_t    rec_reg;

    logic [DW-1:0]        fs_reg;
    logic [DW-1:0]        fq_reg;
    logic [tss_pkg::CNT_W-1:0] fn_reg;
    logic                 fbad_reg;
    logic [DW-1:0]        s2_reg;
    logic [DW-1:0]        qn_reg;
    logic                 fovf_reg;
    logic [DW-1:0]        fres_reg;
    logic [DW-1:0]        vv_reg;

    logic [DW-1:0]        last_min_reg;
    logic [DW-1:0]        least_min_reg;
    logic [DW-1:0]        max_spread_reg;
    logic [tss_pkg::CNT_W-1:0] spurious_reg;
    logic [DW-1:0]        vtot_reg;
    logic [DW-1:0]        vsq_reg;
    logic [DW-1:0]        mtot_reg;
    logic [DW-1:0]        msq_reg;
    logic [DW-1:0]        run_sum_reg;
    logic                 flag_sum_reg;
    logic                 flag_vv_reg;
    logic                 flag_vm_reg;

    logic                 out_valid_reg;
    tss_pkg::result_t     out_reg;

    tss_pkg::mul_req_t    mul_req;
    tss_pkg::mul_rsp_t    mul_rsp;
    tss_pkg::div_req_t    div_req;
    tss_pkg::div_rsp_t    div_rsp;

    logic [DW:0]          run_add;
    logic [DW:0]          tot_add;
    logic [DW:0]          sq_add;
    logic [DW-1:0]        spread;
    logic                 flag_sum_next;
    logic                 prod_hi;

    tss_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    tss_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign pop_ready = state_reg == B_IDLE;
    assign m_tvalid  = out_valid_reg;
    assign m_result  = out_reg;

    always_comb begin
        mul_req.start = 1'b0;
        mul_req.a     = fs_reg;
        mul_req.b     = fs_reg;
        unique case (state_reg)
            B_FV_SS: begin
                mul_req.start = 1'b1;
            end
            B_FV_QN: begin
                mul_req.start = 1'b1;
                mul_req.a     = fq_reg;
                mul_req.b     = DW'(fn_reg);
            end
            B_PV_MUL: begin
                mul_req.start = 1'b1;
                mul_req.a     = fres_reg;
                mul_req.b     = fres_reg;
            end
            B_PM_MUL: begin
                mul_req.start = 1'b1;
                mul_req.a     = rec_reg.row_min;
                mul_req.b     = rec_reg.row_min;
            end
            default: ;
        endcase
    end

    always_comb begin
        div_req.start    = (state_reg == B_FV_CHK) && !fbad_reg && !fovf_reg &&
                           (qn_reg >= s2_reg);
        div_req.dividend = qn_reg - s2_reg;
        div_req.divisor  = tss_pkg::NSQ_W'(fn_reg) * tss_pkg::NSQ_W'(fn_reg);
    end

    always_comb begin
        run_add       = {1'b0, run_sum_reg} + {1'b0, rec_reg.row_sum};
        flag_sum_next = flag_sum_reg || rec_reg.sum_ovf || run_add[DW];
        spread        = rec_reg.row_max - rec_reg.row_min;
        prod_hi       = |mul_rsp.prod[2*DW-1:DW];
        // pair sums: variance pair while in B_PV_*, minimum pair otherwise
        if (state_reg == B_PV_MUL || state_reg == B_PV_MULW) begin
            tot_add = {1'b0, vtot_reg} + {1'b0, fres_reg};
            sq_add  = {1'b0, vsq_reg} + {1'b0, mul_rsp.prod[DW-1:0]};
        end else begin
            tot_add = {1'b0, mtot_reg} + {1'b0, rec_reg.row_min};
            sq_add  = {1'b0, msq_reg} + {1'b0, mul_rsp.prod[DW-1:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= B_IDLE;
            phase_reg      <= PH_ROW;
            out_valid_reg  <= 1'b0;
            last_min_reg   <= '0;
            least_min_reg  <= '1;
            max_spread_reg <= '0;
            spurious_reg   <= '0;
            vtot_reg       <= '0;
            vsq_reg        <= '0;
            mtot_reg       <= '0;
            msq_reg        <= '0;
            run_sum_reg    <= '0;
            flag_sum_reg   <= 1'b0;
            flag_vv_reg    <= 1'b0;
            flag_vm_reg    <= 1'b0;
        end else begin
            // in B_EMIT the emit arm owns the valid flag
            if (out_valid_reg && m_tready && state_reg != B_EMIT) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE: begin
                    if (pop_valid) begin
                        rec_reg   <= pop_data;
                        state_reg <= B_ROW;
                    end
                end
                B_ROW: begin
                    // a zero previous minimum never marks a row spurious
                    if (last_min_reg != '0 && last_min_reg > rec_reg.row_min) begin
                        spurious_reg <= spurious_reg + tss_pkg::CNT_W'(1);
                    end
                    if (rec_reg.row_min < least_min_reg) begin
                        least_min_reg <= rec_reg.row_min;
                    end
                    if (spread > max_spread_reg) begin
                        max_spread_reg <= spread;
                    end
                    run_sum_reg  <= run_add[DW-1:0];
                    flag_sum_reg <= flag_sum_next;
                    last_min_reg <= rec_reg.row_min;
                    fs_reg       <= rec_reg.row_sum;
                    fq_reg       <= rec_reg.row_sq_sum;
                    fn_reg       <= rec_reg.n;
                    fbad_reg     <= rec_reg.sq_ovf || flag_sum_next;
                    phase_reg    <= PH_ROW;
                    state_reg    <= B_FV_SS;
                end
                B_FV_SS: begin
                    state_reg <= B_FV_SSW;
                end
                B_FV_SSW: begin
                    if (mul_rsp.done) begin
                        s2_reg    <= mul_rsp.prod[DW-1:0];
                        fovf_reg  <= prod_hi;
                        state_reg <= B_FV_QN;
                    end
                end
                B_FV_QN: begin
                    state_reg <= B_FV_QNW;
                end
                B_FV_QNW: begin
                    if (mul_rsp.done) begin
                        qn_reg    <= mul_rsp.prod[DW-1:0];
                        fovf_reg  <= fovf_reg || prod_hi;
                        state_reg <= B_FV_CHK;
                    end
                end
                B_FV_CHK: begin
                    if (fbad_reg || fovf_reg) begin
                        fres_reg  <= tss_pkg::VAR_SENTINEL;
                        state_reg <= B_FV_RET;
                    end else if (qn_reg < s2_reg) begin
                        fres_reg  <= '0;
                        state_reg <= B_FV_RET;
                    end else begin
                        state_reg <= B_FV_DIVW;
                    end
                end
                B_FV_DIVW: begin
                    if (div_rsp.done) begin
                        fres_reg  <= div_rsp.quotient;
                        state_reg <= B_FV_RET;
                    end
                end
                B_FV_RET: begin
                    unique case (phase_reg)
                        PH_ROW: begin
                            state_reg <= B_PV_MUL;
                        end
                        PH_VV: begin
                            vv_reg    <= fres_reg;
                            fs_reg    <= mtot_reg;
                            fq_reg    <= msq_reg;
                            fbad_reg  <= flag_vm_reg;
                            phase_reg <= PH_VM;
                            state_reg <= B_FV_SS;
                        end
                        default: begin
                            state_reg <= B_EMIT;
                        end
                    endcase
                end
                B_PV_MUL: begin
                    vtot_reg <= tot_add[DW-1:0];
                    if (tot_add[DW]) begin
                        flag_vv_reg <= 1'b1;
                    end
                    state_reg <= B_PV_MULW;
                end
                B_PV_MULW: begin
                    if (mul_rsp.done) begin
                        vsq_reg <= sq_add[DW-1:0];
                        if (sq_add[DW] || prod_hi) begin
                            flag_vv_reg <= 1'b1;
                        end
                        state_reg <= B_PM_MUL;
                    end
                end
                B_PM_MUL: begin
                    mtot_reg <= tot_add[DW-1:0];
                    if (tot_add[DW]) begin
                        flag_vm_reg <= 1'b1;
                    end
                    state_reg <= B_PM_MULW;
                end
                B_PM_MULW: begin
                    if (mul_rsp.done) begin
                        msq_reg <= sq_add[DW-1:0];
                        if (sq_add[DW] || prod_hi) begin
                            flag_vm_reg <= 1'b1;
                        end
                        state_reg <= rec_reg.last ? B_RUN : B_IDLE;
                    end
                end
                B_RUN: begin
                    if (flag_sum_reg) begin
                        state_reg <= B_EMIT;
                    end else begin
                        fs_reg    <= vtot_reg;
                        fq_reg    <= vsq_reg;
                        fn_reg    <= rec_reg.m;
                        fbad_reg  <= flag_vv_reg;
                        phase_reg <= PH_VV;
                        state_reg <= B_FV_SS;
                    end
                end
                B_EMIT: begin
                    if (!out_valid_reg || m_tready) begin
                        out_valid_reg <= 1'b1;
                        if (flag_sum_reg) begin
                            out_reg <= tss_pkg::result_t'{status: 1'b1, default: '0};
                        end else begin
                            out_reg.status                <= 1'b0;
                            out_reg.spurious_count        <= spurious_reg;
                            out_reg.total_variance        <= vtot_reg;
                            out_reg.max_spread            <= max_spread_reg;
                            out_reg.variance_of_variances <= vv_reg;
                            out_reg.variance_of_minimums  <= fres_reg;
                            out_reg.least_minimum         <= least_min_reg;
                            out_reg.grand_sum             <= run_sum_reg;
                        end
                        last_min_reg   <= '0;
                        least_min_reg  <= '1;
                        max_spread_reg <= '0;
                        spurious_reg   <= '0;
                        vtot_reg       <= '0;
                        vsq_reg        <= '0;
                        mtot_reg       <= '0;
                        msq_reg        <= '0;
                        run_sum_reg    <= '0;
                        flag_sum_reg   <= 1'b0;
                        flag_vv_reg    <= 1'b0;
                        flag_vm_reg    <= 1'b0;
                        state_reg      <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    `TSS_ASSERT(a_err_fields_zero, aclk, aresetn, (out_valid_reg && out_reg.status) |-> (out_reg.spurious_count == '0 && out_reg.grand_sum == '0 && out_reg.least_minimum == '0))
    `TSS_NEVER(a_mul_restart, aclk, aresetn, mul_req.start && mul_rsp.busy)
    `TSS_NEVER(a_div_restart, aclk, aresetn, div_req.start && div_rsp.busy)
    `TSS_ASSERT(a_emit_holds, aclk, aresetn, (state_reg == B_EMIT && out_valid_reg && !m_tready) |=> (state_reg == B_EMIT))

endmodule

[hw/rtl/timing_sample_statistics.sv]
// ----------------------------------------------------------------------------
// Timing sample statistics: top level
// Samples arrive on s_*, one 64-bit value a beat. row_length samples form a
// row and row_count rows form a run; one result beat leaves on m_* per run.
// Registers are written on cfg_* (index 0 row_length, 1 row_count); the user
// must write them only while the block is idle (the block does not enforce
// it); zero acts as 1, values above 4096 act as 4096. The front end squares
// each sample iteratively on one 32x32 multiplier, taking the next once the
// square is done. At each row end the back end works out two products, a
// 64-step divide and two pair squares; at run end, the two run variances. A
// two-row queue between front and back lets samples keep flowing while a row
// is worked out; rows shorter than 14 samples are bound by the back end.
// Reset clears all row and run state and sets both registers to 1. A stalled
// result beat holds in the output register; the back end stops at the next
// run end and the front end stops once the queue is full.
// ----------------------------------------------------------------------------
module timing_sample_statistics (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [63:0]                       s_tdata,   // [63:0] sample
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [12:0] spurious_count, [76:13] total_variance, [140:77] max_spread,
    // [204:141] variance_of_variances, [268:205] variance_of_minimums,
    // [332:269] least_minimum, [396:333] grand_sum, [399:397] zero
    output logic [399:0]                      m_tdata,
    output logic                              m_tuser,   // [0] status
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tss_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tss_pkg::CNT_W-1:0]         cfg_data
);

    logic [tss_pkg::CNT_W-1:0] row_length_reg;
    logic [tss_pkg::CNT_W-1:0] row_count_reg;

    logic              push_valid;
    logic              push_ready;
    tss_pkg::row_rec_t push_data;
    logic              pop_valid;
    logic              pop_ready;
    tss_pkg::row_rec_t pop_data;
    tss_pkg::result_t  result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_length_reg <= tss_pkg::CNT_W'(1);
            row_count_reg  <= tss_pkg::CNT_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                tss_pkg::REG_ROW_LENGTH: row_length_reg <= cfg_data;
                tss_pkg::REG_ROW_COUNT:  row_count_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    tss_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .row_length (row_length_reg),
        .row_count  (row_count_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    tss_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    tss_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_result  (result)
    );

    assign m_tuser = result.status;
    assign m_tdata = {3'b000, result.grand_sum, result.least_minimum,
                      result.variance_of_minimums, result.variance_of_variances,
                      result.max_spread, result.total_variance, result.spurious_count};

endmodule

[verif/tb_timing_sample_statistics.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timing sample statistics testbench
// Streams timing samples through the block under a range of row and run
// settings, predicts each run result and checks every result field.
// ----------------------------------------------------------------------------
module tb_timing_sample_statistics;

    localparam int  LIMIT_CYCLES = 2000000;
    localparam int  SETTLE       = 400;
    localparam int  RANDOM_ITEMS = 1630;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [63:0]                   s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [399:0]                  m_tdata;
    logic                          m_tuser;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [tss_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [tss_pkg::CNT_W-1:0]     cfg_data;

    timing_sample_statistics u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // ---------------- statistics predictor ----------------
    logic [tss_pkg::CNT_W-1:0]  len_reg, cnt_reg;
    logic [63:0] r_min, r_max, r_sum, r_sq;
    bit          r_sq_ovf;
    int unsigned s_idx, rw_idx;
    logic [63:0] last_min, least_min, spread_max;
    logic [tss_pkg::CNT_W-1:0] spur_rows;
    logic [63:0] var_tot, var_sq_tot, min_tot, min_sq_tot, grand;
    bit          ovf_sum, ovf_vv, ovf_vm;

    tss_pkg::result_t runs_expected[$];

    function automatic bit mul_ok(input logic [63:0] a, input logic [63:0] b,
                                  output logic [63:0] p);
        logic [127:0] w;
        w = {64'd0, a} * {64'd0, b};
        p = w[63:0];
        return w[127:64] == 64'd0;
    endfunction

    function automatic int unsigned eff_count(input logic [tss_pkg::CNT_W-1:0] v);
        if (v == 0) return 1;
        return (v > 4096) ? 4096 : v;
    endfunction

    function automatic logic [63:0] pop_variance(input logic [63:0] s, input logic [63:0] q,
                                                 input int unsigned n, input bit bad);
        logic [63:0] s2, qn, nn;
        nn = 64'(n) * 64'(n);
        if (bad || !mul_ok(s, s, s2) || !mul_ok(q, 64'(n), qn)) return tss_pkg::VAR_SENTINEL;
        if (qn < s2) return 64'd0;
        return (qn - s2) / nn;
    endfunction

    task automatic accumulate_pair(input logic [63:0] v, inout logic [63:0] tot,
                                   inout logic [63:0] sq, inout bit flag);
        logic [63:0] p, t;
        t = tot + v;
        if (t < tot) flag = 1;
        tot = t;
        if (!mul_ok(v, v, p)) flag = 1;
        t = sq + p;
        if (t < sq) flag = 1;
        sq = t;
    endtask

    task automatic clear_row_stats();
        r_min = '1; r_max = '0; r_sum = '0; r_sq = '0; r_sq_ovf = 0; s_idx = 0;
    endtask

    task automatic clear_run_stats();
        clear_row_stats();
        rw_idx = 0; last_min = '0; least_min = '1; spread_max = '0; spur_rows = '0;
        var_tot = '0; var_sq_tot = '0; min_tot = '0; min_sq_tot = '0; grand = '0;
        ovf_sum = 0; ovf_vv = 0; ovf_vm = 0;
    endtask

    task automatic predict_sample(input logic [63:0] x);
        logic [63:0] p, t, var_row;
        int unsigned n, m;
        tss_pkg::result_t r;
        if (x < r_min) r_min = x;
        if (x > r_max) r_max = x;
        t = r_sum + x;
        if (t < r_sum) ovf_sum = 1;
        r_sum = t;
        if (!mul_ok(x, x, p)) r_sq_ovf = 1;
        t = r_sq + p;
        if (t < r_sq) r_sq_ovf = 1;
        r_sq = t;
        n = s_idx + 1;
        if (n < eff_count(len_reg)) begin
            s_idx = n;
            return;
        end
        // row end
        if (last_min != 0 && last_min > r_min) spur_rows++;
        if (r_min < least_min) least_min = r_min;
        if (r_max - r_min > spread_max) spread_max = r_max - r_min;
        t = grand + r_sum;
        if (t < grand) ovf_sum = 1;
        grand = t;
        var_row = pop_variance(r_sum, r_sq, n, r_sq_ovf || ovf_sum);
        accumulate_pair(var_row, var_tot, var_sq_tot, ovf_vv);
        accumulate_pair(r_min, min_tot, min_sq_tot, ovf_vm);
        last_min = r_min;
        clear_row_stats();
        m = rw_idx + 1;
        if (m < eff_count(cnt_reg)) begin
            rw_idx = m;
            return;
        end
        r = '0;
        if (ovf_sum) begin
            r.status = 1'b1;
        end else begin
            r.spurious_count        = spur_rows;
            r.total_variance        = var_tot;
            r.max_spread            = spread_max;
            r.variance_of_variances = pop_variance(var_tot, var_sq_tot, m, ovf_vv);
            r.variance_of_minimums  = pop_variance(min_tot, min_sq_tot, m, ovf_vm);
            r.least_minimum         = least_min;
            r.grand_sum             = grand;
        end
        runs_expected.push_back(r);
        clear_run_stats();
    endtask

    // ---------------- sample driver ----------------
    logic [63:0] sample_q[$];
    bit          beat_taken;
    int unsigned burst_left, gap_left;
    int unsigned samples_sent, runs_checked, mismatches, cycles;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || beat_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (sample_q.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= sample_q.pop_front();
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    case ($urandom_range(0, 3))
                        0: gap_left = 0;
                        1: gap_left = $urandom_range(1, 3);
                        2: gap_left = $urandom_range(0, 8);
                        default: gap_left = $urandom_range(10, 40);
                    endcase
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- result receiver ----------------
    int unsigned mode_left, rx_mode, hold_left;
    bit          hold_request;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (hold_request) begin
                hold_request = 0;
                hold_left = 3000;
            end
            if (mode_left == 0) begin
                mode_left = $urandom_range(50, 500);
                rx_mode = $urandom_range(0, 2);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 9) < 7);
                    default: m_tready <= ($urandom_range(0, 9) < 2);
                endcase
            end
        end
    end

    // ---------------- monitor, predictor hookup, timeout ----------------
    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge aclk) begin
        tss_pkg::result_t e;
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end else if (aresetn) begin
            beat_taken = s_tvalid && s_tready;
            if (beat_taken) begin
                predict_sample(s_tdata);
                samples_sent++;
            end
            if (m_tvalid && m_tready) begin
                if (runs_expected.size() == 0) begin
                    mismatches++;
                    $display("%0t: result beat with none expected", $time);
                end else begin
                    e = runs_expected.pop_front();
                    runs_checked++;
                    check_field("status", 64'(e.status), 64'(m_tuser));
                    check_field("spurious_count", 64'(e.spurious_count), 64'(m_tdata[12:0]));
                    check_field("total_variance", e.total_variance, m_tdata[76:13]);
                    check_field("max_spread", e.max_spread, m_tdata[140:77]);
                    check_field("variance_of_variances", e.variance_of_variances,
                                m_tdata[204:141]);
                    check_field("variance_of_minimums", e.variance_of_minimums,
                                m_tdata[268:205]);
                    check_field("least_minimum", e.least_minimum, m_tdata[332:269]);
                    check_field("grand_sum", e.grand_sum, m_tdata[396:333]);
                end
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic wait_idle();
        while (sample_q.size() != 0 || s_tvalid || runs_expected.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [tss_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tss_pkg::CNT_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == tss_pkg::REG_ROW_LENGTH) len_reg = val;
        else if (idx == tss_pkg::REG_ROW_COUNT) cnt_reg = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_shape(input logic [tss_pkg::CNT_W-1:0] len,
                             input logic [tss_pkg::CNT_W-1:0] cnt);
        wait_idle();
        repeat (SETTLE) @(posedge aclk);
        write_reg(tss_pkg::REG_ROW_LENGTH, len);
        write_reg(tss_pkg::REG_ROW_COUNT, cnt);
    endtask

    function automatic logic [63:0] pick_sample(input int unsigned theme);
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 19))
            0: return 64'd0;
            1: return '1;
            2: return v;
            default: begin
                case (theme)
                    0: return 64'($urandom_range(0, 1000));
                    1: return 64'($urandom);
                    2: return v >> $urandom_range(0, 63);
                    default: return 64'd5000 + 64'($urandom_range(0, 200));
                endcase
            end
        endcase
    endfunction

    initial begin
        int unsigned len, cnt, runs, theme, total;
        bit          hold_done;
        aresetn = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        len_reg = 1; cnt_reg = 1;
        clear_run_stats();
        burst_left = 1; gap_left = 0; mode_left = 0; hold_left = 0; hold_request = 0;
        hold_done = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // single-sample rows and runs at reset values
        sample_q = '{64'd0, '1, 64'd1, 64'h1_0000_0000};
        // zero registers act as one
        set_shape(0, 0);
        sample_q = '{64'h8000_0000_0000_0000, 64'd7};
        // row sum overflow
        set_shape(2, 1);
        sample_q = '{'1, '1};
        // spurious rows, then a row after a zero minimum
        set_shape(3, 4);
        sample_q = '{64'd100, 64'd200, 64'd150, 64'd50, 64'd60, 64'd70,
                     64'd0, 64'd9, 64'd5, 64'd7, 64'd8, 64'd9};
        // square overflow gives the sentinel
        set_shape(2, 1);
        sample_q = '{64'h2_0000_0000, 64'd1};

        total = 0;
        while (total < RANDOM_ITEMS) begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            cnt = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
            runs = $urandom_range(1, 3);
            // several runs queued behind a stalled receiver fill the block
            if (!hold_done && total > 400) begin
                len = 2; cnt = 4; runs = 3;
            end
            while (runs > 1 && total + len * cnt * runs > RANDOM_ITEMS) runs--;
            if (total + len * cnt * runs > RANDOM_ITEMS + 40) cnt = 1;
            set_shape(tss_pkg::CNT_W'(len), tss_pkg::CNT_W'(cnt));
            if (!hold_done && total > 400) begin
                hold_done = 1;
                hold_request = 1;
            end
            for (int r = 0; r < runs; r++) begin
                theme = $urandom_range(0, 3);
                for (int i = 0; i < len * cnt; i++) sample_q.push_back(pick_sample(theme));
            end
            total += len * cnt * runs;
        end

        wait_idle();
        repeat (SETTLE) @(posedge aclk);
        $display("covered %0d samples and %0d run results over directed and random shapes",
                 samples_sent, runs_checked);
        if (mismatches == 0 && runs_expected.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
